>>> rtl/pod_pkg.sv
// Shared constants, codes, types and helpers for the probable-owner directory.
`default_nettype none
package pod_pkg;

  localparam int NODES    = 8;
  localparam int BLOCKS   = 64;
  localparam int NODE_W   = $clog2(NODES);
  localparam int BLOCK_W  = $clog2(BLOCKS);
  localparam int PO_DEPTH = NODES * BLOCKS;
  localparam int PO_AW    = NODE_W + BLOCK_W;
  localparam int COPY_W   = 8;
  localparam int HOPS_W   = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  // request kinds (the fourth code is taken as a write)
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_LOCAL_HIT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_OWNER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd4;

  // per-block directory word
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] owner;
    logic [COPY_W-1:0] members;
  } blk_word_t;

  localparam int BLK_WORD_W = $bits(blk_word_t);

  // probable-owner table port
  typedef struct packed {
    logic              we;
    logic [PO_AW-1:0]  waddr;
    logic [NODE_W-1:0] wdata;
    logic [PO_AW-1:0]  raddr;
  } po_port_t;

  // block table port
  typedef struct packed {
    logic               we;
    logic [BLOCK_W-1:0] waddr;
    blk_word_t          wdata;
    logic [BLOCK_W-1:0] raddr;
  } blk_port_t;

  // copy-set bit of a node; nodes beyond the mask width have none
  function automatic logic [COPY_W-1:0] node_bit(input logic [NODE_W-1:0] n);
    logic [COPY_W-1:0] m;
    m = '0;
    if (32'(n) < COPY_W) begin
      m[n] = 1'b1;
    end
    return m;
  endfunction

  // reset pointer of a node: the next node, wrapping
  function automatic logic [NODE_W-1:0] succ_node(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] r;
    r = '0;
    if (32'(n) != NODES - 1) begin
      r = n + NODE_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/probable_owner_directory_top.sv
// Top level of the probable-owner ownership directory.
`default_nettype none
// Ownership directory for shared memory blocks, kept as a dynamic distributed
// manager with probable-owner pointers. A transaction is taken when start is
// high and busy is low; each one yields exactly one result, shown for a single
// cycle with out_valid high. The receiver cannot stall, so results are never
// held. After reset the block runs a clearing pass over all NODES*BLOCKS
// entries that loads every probable-owner pointer with the next node and
// zeroes the block table; busy stays high during it. An insert or a local hit
// is settled in the lookup state; a pointer chase then alternates a hop state
// and a wait state until it reaches the owner, and a chase that gives up after
// NODES hops without an owner is the longest case.
// Each hop that misses the owner costs one read plus one write-back of the
// probable-owner table (single write port, registered read); the hop that
// finds the owner resolves and writes both tables in the same cycle.
// The result is registered and shows in the cycle after the final cycle of
// the transaction.
module probable_owner_directory_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [pod_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [pod_pkg::NODE_W-1:0]     in_node,
  input  wire logic [pod_pkg::BLOCK_W-1:0]    in_block,
  output logic                                out_valid,
  output logic [pod_pkg::STATUS_W-1:0]        out_status,
  output logic [pod_pkg::NODE_W-1:0]          out_serving_node,
  output logic [pod_pkg::HOPS_W-1:0]          out_hops,
  output logic [pod_pkg::NODE_W-1:0]          out_owner_after,
  output logic [pod_pkg::COPY_W-1:0]          out_copy_set
);
  import pod_pkg::*;

  // clearing pass state
  logic              clr_r, clr_nxt;
  logic [PO_AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic              walk_idle;
  logic              go;
  po_port_t          po_walk, po_mem;
  blk_port_t         blk_walk, blk_mem;
  logic [NODE_W-1:0] po_rdata;
  logic [BLK_WORD_W-1:0] blk_rdata_raw;
  blk_word_t         blk_rdata;

  assign busy = clr_r || !walk_idle;
  assign go   = start && !busy;

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + PO_AW'(1);
      if (32'(clr_cnt_r) == PO_DEPTH - 1) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // the sweep owns the write ports while it runs; block rows are rewritten
  // NODES times, harmless since they all get zero
  always_comb begin
    po_mem  = po_walk;
    blk_mem = blk_walk;
    if (clr_r) begin
      po_mem.we      = 1'b1;
      po_mem.waddr   = clr_cnt_r;
      po_mem.wdata   = succ_node(clr_cnt_r[PO_AW-1:BLOCK_W]);
      blk_mem.we     = 1'b1;
      blk_mem.waddr  = clr_cnt_r[BLOCK_W-1:0];
      blk_mem.wdata  = '0;
    end
  end

  assign blk_rdata = blk_rdata_raw;

  pod_ram #(
    .WIDTH (NODE_W),
    .DEPTH (PO_DEPTH)
  ) u_po_ram (
    .clk   (clk),
    .we    (po_mem.we),
    .waddr (po_mem.waddr),
    .wdata (po_mem.wdata),
    .raddr (po_mem.raddr),
    .rdata (po_rdata)
  );

  pod_ram #(
    .WIDTH (BLK_WORD_W),
    .DEPTH (BLOCKS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (blk_mem.we),
    .waddr (blk_mem.waddr),
    .wdata (blk_mem.wdata),
    .raddr (blk_mem.raddr),
    .rdata (blk_rdata_raw)
  );

  pod_walker u_walker (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (go),
    .kind             (in_kind),
    .node             (in_node),
    .blk              (in_block),
    .idle             (walk_idle),
    .po_port          (po_walk),
    .po_rdata         (po_rdata),
    .blk_port         (blk_walk),
    .blk_rdata        (blk_rdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_serving_node (out_serving_node),
    .out_hops         (out_hops),
    .out_owner_after  (out_owner_after),
    .out_copy_set     (out_copy_set)
  );

endmodule
`default_nettype wire

>>> rtl/pod_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module pod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pod_walker.sv
// Request sequencer: looks up the block, chases probable-owner pointers, updates.
`default_nettype none
module pod_walker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           go,
  input  wire logic [pod_pkg::KIND_W-1:0]     kind,
  input  wire logic [pod_pkg::NODE_W-1:0]     node,
  input  wire logic [pod_pkg::BLOCK_W-1:0]    blk,
  output logic                                idle,
  output pod_pkg::po_port_t                   po_port,
  input  wire logic [pod_pkg::NODE_W-1:0]     po_rdata,
  output pod_pkg::blk_port_t                  blk_port,
  input  wire pod_pkg::blk_word_t             blk_rdata,
  output logic                                out_valid,
  output logic [pod_pkg::STATUS_W-1:0]        out_status,
  output logic [pod_pkg::NODE_W-1:0]          out_serving_node,
  output logic [pod_pkg::HOPS_W-1:0]          out_hops,
  output logic [pod_pkg::NODE_W-1:0]          out_owner_after,
  output logic [pod_pkg::COPY_W-1:0]          out_copy_set
);
  import pod_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_HOP  = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [BLOCK_W-1:0]  blk_r, blk_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic [HOPS_W-1:0]   hops_r, hops_nxt;
  blk_word_t           bw_r, bw_nxt;

  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [NODE_W-1:0]   serv_r, serv_nxt;
  logic [HOPS_W-1:0]   ohops_r, ohops_nxt;
  logic [NODE_W-1:0]   own_r, own_nxt;
  logic [COPY_W-1:0]   cset_r, cset_nxt;

  logic [COPY_W-1:0]   new_set;

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    node_nxt   = node_r;
    blk_nxt    = blk_r;
    cur_nxt    = cur_r;
    hops_nxt   = hops_r;
    bw_nxt     = bw_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    serv_nxt   = serv_r;
    ohops_nxt  = ohops_r;
    own_nxt    = own_r;
    cset_nxt   = cset_r;
    new_set    = '0;
    po_port    = '0;
    blk_port   = '0;
    po_port.raddr  = {node, blk};
    blk_port.raddr = blk;

    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          kind_nxt  = kind;
          node_nxt  = node;
          blk_nxt   = blk;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        bw_nxt   = blk_rdata;
        cur_nxt  = po_rdata;
        hops_nxt = HOPS_W'(1);
        if (kind_r == KIND_INSERT) begin
          blk_port.we            = 1'b1;
          blk_port.waddr         = blk_r;
          blk_port.wdata.valid   = 1'b1;
          blk_port.wdata.owner   = node_r;
          blk_port.wdata.members = node_bit(node_r);
          valid_nxt  = 1'b1;
          status_nxt = ST_INSERTED;
          serv_nxt   = node_r;
          ohops_nxt  = '0;
          own_nxt    = node_r;
          cset_nxt   = node_bit(node_r);
          state_nxt  = S_IDLE;
        end else if (blk_rdata.valid && blk_rdata.owner == node_r) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_LOCAL_HIT;
          serv_nxt   = node_r;
          ohops_nxt  = '0;
          own_nxt    = blk_rdata.owner;
          cset_nxt   = blk_rdata.members;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_HOP;
        end
      end

      S_HOP: begin
        po_port.raddr = {cur_r, blk_r};
        if (bw_r.valid && bw_r.owner == cur_r) begin
          valid_nxt      = 1'b1;
          serv_nxt       = cur_r;
          ohops_nxt      = hops_r;
          blk_port.we    = 1'b1;
          blk_port.waddr = blk_r;
          po_port.we     = 1'b1;
          if (kind_r == KIND_READ) begin
            new_set                = bw_r.members | node_bit(node_r);
            blk_port.wdata         = bw_r;
            blk_port.wdata.members = new_set;
            po_port.waddr          = {node_r, blk_r};
            po_port.wdata          = cur_r;
            status_nxt             = ST_READ;
            own_nxt                = bw_r.owner;
          end else begin
            new_set                = bw_r.members | node_bit(cur_r);
            blk_port.wdata.valid   = 1'b1;
            blk_port.wdata.owner   = node_r;
            blk_port.wdata.members = new_set;
            po_port.waddr          = {cur_r, blk_r};
            po_port.wdata          = node_r;
            status_nxt             = ST_WRITE;
            own_nxt                = node_r;
          end
          cset_nxt  = new_set;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end

      S_WAIT: begin
        // repoint the visited node at the requester, step to its old pointer
        po_port.we    = 1'b1;
        po_port.waddr = {cur_r, blk_r};
        po_port.wdata = node_r;
        cur_nxt       = po_rdata;
        if (hops_r == HOPS_W'(NODES)) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_NO_OWNER;
          serv_nxt   = '0;
          ohops_nxt  = hops_r;
          own_nxt    = bw_r.owner;
          cset_nxt   = bw_r.members;
          state_nxt  = S_IDLE;
        end else begin
          hops_nxt  = hops_r + HOPS_W'(1);
          state_nxt = S_HOP;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    node_r   <= node_nxt;
    blk_r    <= blk_nxt;
    cur_r    <= cur_nxt;
    hops_r   <= hops_nxt;
    bw_r     <= bw_nxt;
    status_r <= status_nxt;
    serv_r   <= serv_nxt;
    ohops_r  <= ohops_nxt;
    own_r    <= own_nxt;
    cset_r   <= cset_nxt;
  end

  assign idle             = (state_r == S_IDLE);
  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_serving_node = serv_r;
  assign out_hops         = ohops_r;
  assign out_owner_after  = own_r;
  assign out_copy_set     = cset_r;

endmodule
`default_nettype wire

>>> verif/pod_dir_check_pkg.sv
// Scoreboard for the probable-owner directory: directory predictor and result checks.
package pod_dir_check_pkg;
  import pod_pkg::*;

  // the fourth kind code is handled as a write
  localparam logic [KIND_W-1:0] KIND_WRITE_ALIAS = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   serving;
    logic [HOPS_W-1:0]   hops;
    logic [NODE_W-1:0]   owner;
    logic [COPY_W-1:0]   copy_set;
  } dir_result_t;

  class directory_scoreboard;
    logic [NODE_W-1:0] pointer_tbl [NODES][BLOCKS];
    logic [NODE_W-1:0] owner_tbl [BLOCKS];
    bit                owned [BLOCKS];
    logic [COPY_W-1:0] sharers [BLOCKS];
    dir_result_t       pending_results [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      for (int n = 0; n < NODES; n++) begin
        for (int b = 0; b < BLOCKS; b++) begin
          pointer_tbl[n][b] = NODE_W'((n + 1) % NODES);
        end
      end
      for (int b = 0; b < BLOCKS; b++) begin
        owner_tbl[b] = '0;
        owned[b]     = 1'b0;
        sharers[b]   = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    // walk the pointer chain for one accepted transaction and queue its result
    function void note_request(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node,
                               logic [BLOCK_W-1:0] blk);
      dir_result_t       r;
      logic [NODE_W-1:0] cur;
      logic [NODE_W-1:0] nxt;
      int                hop_cnt;
      r = '0;
      if (kind == KIND_INSERT) begin
        owner_tbl[blk] = node;
        owned[blk]     = 1'b1;
        sharers[blk]   = COPY_W'(1) << node;
        r.status       = ST_INSERTED;
        r.serving      = node;
      end else if (owned[blk] && owner_tbl[blk] == node) begin
        r.status  = ST_LOCAL_HIT;
        r.serving = node;
      end else begin
        cur      = pointer_tbl[node][blk];
        r.status = ST_NO_OWNER;
        hop_cnt  = 0;
        for (int h = 1; h <= NODES; h++) begin
          hop_cnt = h;
          if (owned[blk] && owner_tbl[blk] == cur) begin
            r.serving = cur;
            if (kind == KIND_READ) begin
              sharers[blk]          = sharers[blk] | (COPY_W'(1) << node);
              pointer_tbl[node][blk] = cur;
              r.status              = ST_READ;
            end else begin
              sharers[blk]         = sharers[blk] | (COPY_W'(1) << cur);
              owner_tbl[blk]       = node;
              pointer_tbl[cur][blk] = node;
              r.status             = ST_WRITE;
            end
            break;
          end
          nxt                   = pointer_tbl[cur][blk];
          pointer_tbl[cur][blk] = node;
          cur                   = nxt;
        end
        if (hop_cnt > 15) hop_cnt = 15;
        r.hops = HOPS_W'(hop_cnt);
      end
      r.owner    = owner_tbl[blk];
      r.copy_set = sharers[blk];
      pending_results = {pending_results, r};
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t mismatch, transaction %0d, %s: got %0d want %0d",
               $time, checked, what, got, want);
      errors++;
    endtask

    task check_result(dir_result_t got);
      dir_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.serving !== want.serving)
          report_mismatch("serving_node", got.serving, want.serving);
        if (got.hops !== want.hops)
          report_mismatch("hops", got.hops, want.hops);
        if (got.owner !== want.owner)
          report_mismatch("owner_after", got.owner, want.owner);
        if (got.copy_set !== want.copy_set)
          report_mismatch("copy_set", got.copy_set, want.copy_set);
      end
      checked++;
    endtask

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

>>> verif/tb_probable_owner_directory_top.sv
// Self-checking testbench for the probable-owner ownership directory top level.
module tb_probable_owner_directory_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pod_pkg::*;
  import pod_dir_check_pkg::*;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                start    = 1'b0;
  logic [KIND_W-1:0]   in_kind  = KIND_INSERT;
  logic [NODE_W-1:0]   in_node  = '0;
  logic [BLOCK_W-1:0]  in_block = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [NODE_W-1:0]   out_serving_node;
  logic [HOPS_W-1:0]   out_hops;
  logic [NODE_W-1:0]   out_owner_after;
  logic [COPY_W-1:0]   out_copy_set;

  directory_scoreboard sb = new();

  // Number of random transactions, and how many hot blocks most of them go to.
  localparam int unsigned RANDOM_TXNS = 1500;
  localparam int unsigned HOT_BLOCKS  = 6;

  probable_owner_directory_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_node          (in_node),
    .in_block         (in_block),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_serving_node (out_serving_node),
    .out_hops         (out_hops),
    .out_owner_after  (out_owner_after),
    .out_copy_set     (out_copy_set)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor. Everything here is sampled at the rising edge, so it sees the
  // values that were stable before the edge: the driver's nonblocking updates
  // and the DUT's register updates both land later in the same time step.
  // A transaction is predicted the moment it is accepted; a result is registered
  // and always comes after its own acceptance, so order is safe.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_request(in_kind, in_node, in_block);
    end
    if (rst_n && out_valid) begin
      sb.check_result('{status:   out_status,
                        serving:  out_serving_node,
                        hops:     out_hops,
                        owner:    out_owner_after,
                        copy_set: out_copy_set});
    end
  end

  // Idle time between transactions: mostly none or short, now and
  // then a long pause so gaps land on every phase of a pointer chase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Present one transaction and hold it until the DUT takes it. With a zero
  // gap start stays high, so the next call only refreshes the fields and
  // start never gets two assignments in the same step.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] node,
                       input logic [BLOCK_W-1:0] blk, input int unsigned gap);
    start    <= 1'b1;
    in_kind  <= kind;
    in_node  <= node;
    in_block <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [KIND_W-1:0]  kind;
    logic [NODE_W-1:0]  node;
    logic [BLOCK_W-1:0] blk;
    int unsigned        r;
    bit                 burst;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The DUT is still in its clearing pass here, so the
    // first transaction also checks that busy holds it off.
    // Never-inserted blocks: full-length chase, no owner found.
    issue(KIND_READ,  3'd0, 6'd0,  pick_gap());
    issue(KIND_WRITE, 3'd7, 6'd63, pick_gap());
    // Insert, then a local hit by the owner.
    issue(KIND_INSERT, 3'd0, 6'd0, pick_gap());
    issue(KIND_READ,   3'd0, 6'd0, pick_gap());
    // Remote read twice: the second one finds a short path to the owner.
    issue(KIND_READ,  3'd5, 6'd0, pick_gap());
    issue(KIND_READ,  3'd5, 6'd0, pick_gap());
    // Ownership moves by a write, then by the fourth kind code.
    issue(KIND_WRITE,       3'd3, 6'd0, pick_gap());
    issue(KIND_WRITE_ALIAS, 3'd6, 6'd0, pick_gap());
    issue(KIND_READ,        3'd0, 6'd0, pick_gap());
    // Highest node and block.
    issue(KIND_INSERT, 3'd7, 6'd63, pick_gap());
    issue(KIND_WRITE,  3'd0, 6'd63, pick_gap());
    issue(KIND_READ,   3'd7, 6'd63, pick_gap());
    // Insert over an existing owner drops the old copy set.
    issue(KIND_INSERT, 3'd2, 6'd0, pick_gap());
    issue(KIND_READ,   3'd2, 6'd0, pick_gap());
    issue(KIND_WRITE,  3'd2, 6'd0, pick_gap());
    // Fourth kind code on an unowned block.
    issue(KIND_WRITE_ALIAS, 3'd4, 6'd32, pick_gap());
    // Alternating bit patterns on the blocks and on the inserting nodes.
    issue(KIND_INSERT, 3'd5, 6'd21, pick_gap());
    issue(KIND_INSERT, 3'd2, 6'd42, pick_gap());
    issue(KIND_READ,   3'd1, 6'd42, pick_gap());
    issue(KIND_WRITE,  3'd6, 6'd21, pick_gap());
    issue(KIND_READ,   3'd5, 6'd21, pick_gap());

    // Random part. Most traffic goes to a handful of blocks so that chains
    // grow long and ownership changes hands often; the rest spreads over the
    // whole address range. Every 64 transactions a burst mode may switch
    // off idling altogether.
    burst = 1'b0;
    for (int unsigned i = 0; i < RANDOM_TXNS; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15)      kind = KIND_INSERT;
      else if (r < 55) kind = KIND_READ;
      else if (r < 95) kind = KIND_WRITE;
      else             kind = KIND_WRITE_ALIAS;
      node = NODE_W'($urandom_range(0, NODES - 1));
      if ($urandom_range(0, 99) < 75) blk = BLOCK_W'($urandom_range(0, HOT_BLOCKS - 1));
      else                            blk = BLOCK_W'($urandom_range(0, BLOCKS - 1));
      issue(kind, node, blk, burst ? 0 : pick_gap());
    end
    // A zero last gap leaves start high; this is the only write to it now.
    start <= 1'b0;

    // Drain, then give the DUT time to show any stray result.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_probable_owner_directory_top: clean");
    end else begin
      $display("tb_probable_owner_directory_top: errors");
    end
    $finish;
  end

  // Watchdog. It allows about five times the slowest correct run: the
  // clearing pass and about 1520 transactions of the longest kind, each with
  // the longest gap.
  initial begin
    #5ms;
    $display("tb_probable_owner_directory_top: errors");
    $finish;
  end

endmodule
